// File: rtl/nce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nce_pkg
// Shared types and opcode constants of the nibble CPU execute step.
// ----------------------------------------------------------------------------
package nce_pkg;

    // command codes
    localparam logic CMD_EXEC  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // opcode fields
    localparam logic [7:0] OP_LDW_IND = 8'h42;  // LDW ACC,RAM[RC:RB:RA]
    localparam int unsigned MODE_BIT  = 14;     // bit 6 of the opcode byte

    // low nibble of the opcode: operation
    localparam logic [3:0] LO_LDI  = 4'h0;
    localparam logic [3:0] LO_NAND = 4'h1;
    localparam logic [3:0] LO_LDW  = 4'h2;
    localparam logic [3:0] LO_LDA  = 4'h3;
    localparam logic [3:0] LO_OUTA = 4'h4;
    localparam logic [3:0] LO_OUTB = 4'h5;
    localparam logic [3:0] LO_OUTC = 4'h6;
    localparam logic [3:0] LO_LDR  = 4'h7;
    localparam logic [3:0] LO_CMP  = 4'h8;
    localparam logic [3:0] LO_OUTD = 4'h9;

    // high nibble of the opcode: operand select
    localparam logic [3:0] HI_IMM = 4'h0;
    localparam logic [3:0] HI_RA  = 4'h1;
    localparam logic [3:0] HI_RB  = 4'h2;
    localparam logic [3:0] HI_RAM = 4'h3;

    typedef struct packed {
        logic        command;
        logic [15:0] instr_word;
        logic [11:0] ram_address;
        logic [3:0]  ram_data;
    } t_in_word;

    typedef struct packed {
        logic [11:0] pc;
        logic [3:0]  acc;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [3:0]  reg_c;
        logic        flag_zero;
        logic        flag_carry;
        logic [3:0]  port_a;
        logic [3:0]  port_b;
        logic [3:0]  port_c;
        logic [3:0]  port_d;
        logic        bad_opcode;
    } t_out_word;

    typedef struct packed {
        logic [11:0] pc;
        logic [3:0]  acc;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [3:0]  rc;
        logic        z;
        logic        c;
        logic [3:0]  port_a;
        logic [3:0]  port_b;
        logic [3:0]  port_c;
        logic [3:0]  port_d;
    } t_cpu_state;

endpackage
`default_nettype wire

// File: rtl/nibble_cpu_execute_step_core.sv
// A word passes the input register, the RAM read register and the result
// register in that order. Throughput: one word per cycle unless the output
// stalls or the RAM is clearing; each register hands on as the next frees up.
// Reset (i_rst_n low, synchronous): clears PC, ACC, RA/RB/RC, flags, ports.
// The data RAM is then zeroed by a clearing pass over all RAM_DEPTH entries,
// during which o_in_ready stays low.
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_cpu_execute_step_core
// Execute step of a 4-bit CPU: runs one instruction word or preloads one RAM
// nibble per input word and returns the machine state after each step.
// ----------------------------------------------------------------------------
module nibble_cpu_execute_step_core #(
    parameter int RAM_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire nce_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output nce_pkg::t_out_word      o_out_word
);
    import nce_pkg::*;

    // stage 1: input register
    t_in_word   r_in;
    logic       r_in_valid;
    // stage 2: word waiting on its RAM read data
    t_in_word   r_s2;
    logic       r_s2_valid;
    // result register
    t_out_word  r_out;
    logic       r_out_valid;
    // architectural state
    t_cpu_state r_st;
    t_cpu_state n_st;

    t_cpu_state ex_nxt;
    logic       ex_bad;
    logic [3:0] ram_q;
    logic       ram_busy;
    logic [11:0] rd_addr;

    logic out_free;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic in_go;

    // handshake chain, back to front
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_go      = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || s2_go;
    assign s1_go      = r_in_valid && s2_free;
    assign o_in_ready = (!r_in_valid || s1_go) && !ram_busy;
    assign in_go      = i_in_valid && o_in_ready;

    nce_exec u_exec (
        .i_word (r_s2),
        .i_cur  (r_st),
        .i_mem  (ram_q),
        .o_nxt  (ex_nxt),
        .o_bad  (ex_bad)
    );

    // state after the stage 2 word retires this cycle
    assign n_st = s2_go ? ex_nxt : r_st;

    // RAM read address of the stage 1 word, built from the registers as the
    // word ahead of it leaves them (RA/RB/RC never depend on RAM data)
    always_comb begin
        if (r_in.instr_word[MODE_BIT]) begin
            rd_addr = {n_st.rc, n_st.rb, n_st.ra};
        end else begin
            rd_addr = {n_st.rc, r_in.instr_word[7:0]};
        end
    end

    // write commands hit the RAM when they retire, keeping program order;
    // the RAM forwards a write that lands on the address being read
    nce_ram #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s1_go),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q),
        .i_wr_en   (s2_go && (r_s2.command == CMD_WRITE)),
        .i_wr_addr (r_s2.ram_address),
        .i_wr_data (r_s2.ram_data),
        .o_busy    (ram_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            r_st <= n_st;
            if (in_go) begin
                r_in_valid <= 1'b1;
            end else if (s1_go) begin
                r_in_valid <= 1'b0;
            end
            if (s1_go) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_in <= i_in_word;
        end
        if (s1_go) begin
            r_s2 <= r_in;
        end
        if (s2_go) begin
            r_out.pc         <= ex_nxt.pc;
            r_out.acc        <= ex_nxt.acc;
            r_out.reg_a      <= ex_nxt.ra;
            r_out.reg_b      <= ex_nxt.rb;
            r_out.reg_c      <= ex_nxt.rc;
            r_out.flag_zero  <= ex_nxt.z;
            r_out.flag_carry <= ex_nxt.c;
            r_out.port_a     <= ex_nxt.port_a;
            r_out.port_b     <= ex_nxt.port_b;
            r_out.port_c     <= ex_nxt.port_c;
            r_out.port_d     <= ex_nxt.port_d;
            r_out.bad_opcode <= ex_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

// File: rtl/nce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nce_ram
// Nibble data RAM: one write and one registered read port, address folding
// modulo the depth, read-during-write bypass and a clearing pass after reset.
// ----------------------------------------------------------------------------
module nce_ram #(
    parameter int RAM_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [11:0] i_rd_addr,
    output logic      [3:0]  o_rd_data,
    input  wire logic        i_wr_en,
    input  wire logic [11:0] i_wr_addr,
    input  wire logic [3:0]  i_wr_data,
    output logic             o_busy
);
    localparam int IDX_W = $clog2(RAM_DEPTH);

    logic [3:0]       mem [RAM_DEPTH];
    logic [3:0]       r_q;
    logic             r_byp_v;
    logic [3:0]       r_byp_d;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    // address mod depth in four restoring steps; exact only while the quotient is below 16 (RAM_DEPTH >= 256)
    function automatic logic [IDX_W-1:0] f_index(input logic [11:0] a);
        logic [15:0] r;
        logic [15:0] d;
        r = {4'b0, a};
        for (int k = 3; k >= 0; k--) begin
            d = 16'(RAM_DEPTH) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[IDX_W-1:0];
    endfunction

    assign rd_idx = f_index(i_rd_addr);
    assign wr_idx = f_index(i_wr_addr);

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_idx] <= 4'h0;
        end else if (i_wr_en) begin
            mem[wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q     <= mem[rd_idx];
            r_byp_d <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_v    <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            if (i_rd_en) begin
                r_byp_v <= i_wr_en && (wr_idx == rd_idx);
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(RAM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rd_data = r_byp_v ? r_byp_d : r_q;
    assign o_busy    = r_clr_busy;

endmodule
`default_nettype wire

// File: rtl/nce_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nce_exec
// Instruction decode and nibble ALU: next machine state for one word.
// ----------------------------------------------------------------------------
module nce_exec (
    input  wire nce_pkg::t_in_word   i_word,
    input  wire nce_pkg::t_cpu_state i_cur,
    input  wire logic [3:0]          i_mem,
    output nce_pkg::t_cpu_state      o_nxt,
    output logic                     o_bad
);
    import nce_pkg::*;

    logic [7:0] op;
    logic [3:0] hi;
    logic [3:0] lo;
    logic [3:0] n;
    logic [3:0] src;
    logic [3:0] reg_sel;
    logic [3:0] out_v;
    logic [3:0] nand_v;

    assign op = i_word.instr_word[15:8];
    assign hi = op[7:4];
    assign lo = op[3:0];
    assign n  = i_word.instr_word[3:0];

    always_comb begin
        case (hi)
            HI_IMM:  src = n;
            HI_RA:   src = i_cur.ra;
            HI_RB:   src = i_cur.rb;
            default: src = i_mem;
        endcase
        case (hi)
            HI_RA:   reg_sel = i_cur.ra;
            HI_RB:   reg_sel = i_cur.rb;
            default: reg_sel = i_cur.rc;
        endcase
        // OUTx sources differ: n, ACC, RA, RAM
        case (hi)
            HI_IMM:  out_v = n;
            HI_RA:   out_v = i_cur.acc;
            HI_RB:   out_v = i_cur.ra;
            default: out_v = i_mem;
        endcase
    end

    assign nand_v = ~(i_cur.acc & src);

    always_comb begin
        o_nxt = i_cur;
        o_bad = 1'b0;
        if (i_word.command == CMD_EXEC) begin
            o_nxt.pc = i_cur.pc + 12'd1;
            if (op == OP_LDW_IND) begin
                o_nxt.acc = i_mem;
                o_nxt.z   = (i_mem == 4'h0);
            end else if (hi[3] || hi[2]) begin
                o_bad = 1'b1;
            end else begin
                case (lo)
                    LO_LDI: begin
                        case (hi)
                            HI_IMM: begin
                                o_nxt.acc = n;
                                o_nxt.z   = (n == 4'h0);
                            end
                            HI_RA:   o_nxt.ra = n;
                            HI_RB:   o_nxt.rb = n;
                            default: o_nxt.rc = n;
                        endcase
                    end
                    LO_NAND: begin
                        o_nxt.acc = nand_v;
                        o_nxt.z   = (nand_v == 4'h0);
                    end
                    LO_LDW: begin
                        if (hi != HI_IMM) begin
                            o_bad = 1'b1;
                        end else begin
                            o_nxt.acc = i_mem;
                            o_nxt.z   = (i_mem == 4'h0);
                        end
                    end
                    LO_LDA: begin
                        if (hi == HI_IMM) begin
                            o_bad = 1'b1;
                        end else begin
                            o_nxt.acc = reg_sel;
                            o_nxt.z   = (reg_sel == 4'h0);
                        end
                    end
                    LO_LDR: begin
                        case (hi)
                            HI_IMM:  o_bad    = 1'b1;
                            HI_RA:   o_nxt.ra = i_cur.acc;
                            HI_RB:   o_nxt.rb = i_cur.acc;
                            default: o_nxt.rc = i_cur.acc;
                        endcase
                    end
                    LO_CMP: begin
                        o_nxt.z = (i_cur.acc == src);
                        o_nxt.c = (i_cur.acc >= src);
                    end
                    LO_OUTA: o_nxt.port_a = out_v;
                    LO_OUTB: o_nxt.port_b = out_v;
                    LO_OUTC: o_nxt.port_c = out_v;
                    LO_OUTD: o_nxt.port_d = out_v;
                    default: o_bad = 1'b1;
                endcase
            end
        end
    end

endmodule
`default_nettype wire
